// ===== sv/sphda_pkg.sv =====
package sphda_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_SQZ,
    ST_HSQ,
    ST_SQRT,
    ST_UDIV,
    ST_T,
    ST_T2,
    ST_TMUL,
    ST_TDIV,
    ST_S,
    ST_TH,
    ST_C,
    ST_C2,
    ST_C4,
    ST_C6,
    ST_MK,
    ST_N,
    ST_H2,
    ST_H3,
    ST_TDV,
    ST_DONE
  } state_t;

  localparam logic [47:0] DENS_MAX    = 48'hFFFF_FFFF_FFFF;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [30:0] PIH_Q30     = 31'd1686629713;
  localparam logic [18:0] U_SAT       = 19'h40000;
  localparam logic [31:0] KNORM_RST   = 32'd51801;
  localparam logic [2:0]  TAYLOR_LAST = 3'd4;

  localparam logic [6:0] MUL_STEPS  = 7'd33;
  localparam logic [6:0] SQRT_STEPS = 7'd32;
  localparam logic [6:0] DIV_W_U    = 7'd48;
  localparam logic [6:0] DIV_W_TAY  = 7'd32;
  localparam logic [6:0] DIV_W_SINC = 7'd64;
  localparam logic [6:0] DIV_W_TERM = 7'd97;

  // Divisors of the nested sine series, innermost first.
  function automatic logic [6:0] taylor_div(input logic [2:0] k);
    logic [6:0] d;
    unique case (k)
      3'd0:    d = 7'd110;
      3'd1:    d = 7'd72;
      3'd2:    d = 7'd42;
      3'd3:    d = 7'd20;
      default: d = 7'd6;
    endcase
    return d;
  endfunction

endpackage

// ===== sv/sph_density_accumulator.sv =====
// Channel | Direction | Handshake         | Payload
// in_     | input     | in_valid/in_stall | kind, pos_x/y/z, smoothing_length, mass, last_term
// out_    | output    | out_valid/out_stall | density, overflow
// cfg_    | input     | cfg_valid/cfg_ready | data (kernel_norm)
// Items run through a bit-serial multiplier, a radix-2 divider (one quotient bit per cycle,
// up to 97 bits) and a square root unit (one result bit per cycle), all shared by one
// sequencer; an item past the neighbor limit goes straight to the done state. No new item
// is taken until the sequencer is back in idle.
// Synchronous active-low reset restores kernel_norm and clears all accumulator state.
// A result waits in the output register under out_stall while the next item is taken.
module sph_density_accumulator #(
  parameter int MAX_NEIGHBORS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic        [31:0] in_smoothing_length,
  input  logic        [31:0] in_mass,
  input  logic               in_last_term,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [47:0] out_density,
  output logic               out_overflow,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [31:0] cfg_data
);

  localparam int NBW = $clog2(MAX_NEIGHBORS + 1);
  localparam logic [NBW-1:0] NB_MAX = NBW'(MAX_NEIGHBORS);

  sphda_pkg::state_t state_r, state_nxt;
  logic        run_r, run_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [31:0] kreg_r, kreg_nxt;
  logic signed [31:0] own_x_r, own_x_nxt, own_y_r, own_y_nxt, own_z_r, own_z_nxt;
  logic [31:0] own_h_r, own_h_nxt;
  logic [47:0] dsum_r, dsum_nxt;
  logic        err_r, err_nxt;
  logic [NBW-1:0] nb_r, nb_nxt;
  logic signed [31:0] px_r, px_nxt, py_r, py_nxt, pz_r, pz_nxt;
  logic [31:0] mass_r, mass_nxt;
  logic        last_r, last_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [47:0] out_den_r, out_den_nxt;
  logic        out_ovf_r, out_ovf_nxt;

  logic [63:0]  mul_a_r, mul_a_nxt;
  logic [32:0]  mul_b_r, mul_b_nxt;
  logic [96:0]  acc_r, acc_nxt;
  logic [127:0] num_r, num_nxt;
  logic [95:0]  den_r, den_nxt, rem_r, rem_nxt;
  logic [63:0]  q_r, q_nxt;
  logic         big_r, big_nxt;
  logic [63:0]  sv_r, sv_nxt;
  logic [33:0]  srem_r, srem_nxt;
  logic [31:0]  root_r, root_nxt;

  logic [31:0] ax_r, ax_nxt, ay_r, ay_nxt, az_r, az_nxt, hh_r, hh_nxt;
  logic [63:0] d2_r, d2_nxt;
  logic [18:0] u_r, u_nxt;
  logic [31:0] t_r, t_nxt, t2_r, t2_nxt, y_r, y_nxt, s_r, s_nxt;
  logic [30:0] p_r, p_nxt;
  logic [2:0]  tk_r, tk_nxt;
  logic [32:0] theta_r, theta_nxt;
  logic [30:0] c_r, c_nxt, c2_r, c2_nxt, c4_r, c4_nxt, c6_r, c6_nxt;
  logic [63:0] mk_r, mk_nxt, hsq_r, hsq_nxt;
  logic [96:0] n_r, n_nxt;
  logic [95:0] hc_r, hc_nxt;

  logic        accept, fin, step;
  logic        mul_go, div_go, sqrt_go;
  logic [63:0] mul_ina;
  logic [32:0] mul_inb;
  logic [127:0] div_num;
  logic [95:0] div_den;
  logic [6:0]  div_w;
  logic [96:0] rem_sh;
  logic        div_ge;
  logic [35:0] s_sh, s_trial;
  logic        s_ge;
  logic [32:0] dxa, dya, dza;
  logic        big_d;
  logic [16:0] g_val;
  logic        do_acc, acc_sat;
  logic [47:0] acc_t;
  logic [48:0] sum49;

  function automatic logic [32:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    return d[32] ? (~d + 33'd1) : d;
  endfunction

  assign in_stall     = (state_r != sphda_pkg::ST_IDLE);
  assign accept       = in_valid && !in_stall;
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_density  = out_den_r;
  assign out_overflow = out_ovf_r;

  assign fin  = run_r && (cnt_r == 7'd0);
  assign step = run_r && (cnt_r != 7'd0);

  assign dxa   = abs_diff(own_x_r, px_r);
  assign dya   = abs_diff(own_y_r, py_r);
  assign dza   = abs_diff(own_z_r, pz_r);
  assign big_d = dxa[32] | dxa[31] | dya[32] | dya[31] | dza[32] | dza[31];
  assign g_val = u_r[16] ? (17'h10000 - {1'b0, u_r[15:0]}) : {1'b0, u_r[15:0]};

  assign rem_sh  = {rem_r, num_r[127]};
  assign div_ge  = (rem_sh >= {1'b0, den_r});
  assign s_sh    = {srem_r, sv_r[63:62]};
  assign s_trial = {2'b00, root_r, 2'b01};
  assign s_ge    = (s_sh >= s_trial);
  assign sum49   = {1'b0, dsum_r} + {1'b0, acc_t};

  always_comb begin
    state_nxt = state_r;    run_nxt = run_r;        cnt_nxt = cnt_r;
    kreg_nxt = kreg_r;      own_x_nxt = own_x_r;    own_y_nxt = own_y_r;
    own_z_nxt = own_z_r;    own_h_nxt = own_h_r;    dsum_nxt = dsum_r;
    err_nxt = err_r;        nb_nxt = nb_r;          px_nxt = px_r;
    py_nxt = py_r;          pz_nxt = pz_r;          mass_nxt = mass_r;
    last_nxt = last_r;      out_valid_nxt = out_valid_r;
    out_den_nxt = out_den_r; out_ovf_nxt = out_ovf_r;
    mul_a_nxt = mul_a_r;    mul_b_nxt = mul_b_r;    acc_nxt = acc_r;
    num_nxt = num_r;        den_nxt = den_r;        rem_nxt = rem_r;
    q_nxt = q_r;            big_nxt = big_r;        sv_nxt = sv_r;
    srem_nxt = srem_r;      root_nxt = root_r;
    ax_nxt = ax_r;          ay_nxt = ay_r;          az_nxt = az_r;
    hh_nxt = hh_r;          d2_nxt = d2_r;          u_nxt = u_r;
    t_nxt = t_r;            t2_nxt = t2_r;          y_nxt = y_r;
    s_nxt = s_r;            p_nxt = p_r;            tk_nxt = tk_r;
    theta_nxt = theta_r;    c_nxt = c_r;            c2_nxt = c2_r;
    c4_nxt = c4_r;          c6_nxt = c6_r;          mk_nxt = mk_r;
    hsq_nxt = hsq_r;        n_nxt = n_r;            hc_nxt = hc_r;

    mul_go = 1'b0;  mul_ina = '0;  mul_inb = '0;
    div_go = 1'b0;  div_num = '0;  div_den = '0;  div_w = 7'd0;
    sqrt_go = 1'b0;
    do_acc = 1'b0;  acc_sat = 1'b0;  acc_t = '0;

    if (cfg_valid) begin
      kreg_nxt = cfg_data;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // All three serial units advance together; only the one loaded last matters.
    if (step) begin
      cnt_nxt   = cnt_r - 7'd1;
      acc_nxt   = {acc_r[95:0], 1'b0} + (mul_b_r[32] ? {33'b0, mul_a_r} : 97'b0);
      mul_b_nxt = {mul_b_r[31:0], 1'b0};
      rem_nxt   = div_ge ? 96'(rem_sh - {1'b0, den_r}) : rem_sh[95:0];
      num_nxt   = {num_r[126:0], 1'b0};
      if (!big_r) begin
        if (q_r[63:47] != 17'd0) begin
          big_nxt = 1'b1;
        end else begin
          q_nxt = {q_r[62:0], div_ge};
        end
      end
      srem_nxt = s_ge ? 34'(s_sh - s_trial) : s_sh[33:0];
      root_nxt = {root_r[30:0], s_ge};
      sv_nxt   = {sv_r[61:0], 2'b00};
    end
    if (fin) begin
      run_nxt = 1'b0;
    end

    unique case (state_r)
      sphda_pkg::ST_IDLE: begin
        if (accept) begin
          px_nxt   = in_pos_x;
          py_nxt   = in_pos_y;
          pz_nxt   = in_pos_z;
          mass_nxt = in_mass;
          last_nxt = in_last_term;
          if (!in_kind) begin
            own_x_nxt = in_pos_x;
            own_y_nxt = in_pos_y;
            own_z_nxt = in_pos_z;
            own_h_nxt = in_smoothing_length;
            dsum_nxt  = '0;
            err_nxt   = 1'b0;
            nb_nxt    = '0;
            c6_nxt    = sphda_pkg::ONE_Q30;
            state_nxt = sphda_pkg::ST_MK;
          end else if (nb_r < NB_MAX) begin
            nb_nxt    = nb_r + NBW'(1);
            state_nxt = (own_h_r == 32'd0) ? sphda_pkg::ST_MK : sphda_pkg::ST_DIFF;
          end else begin
            state_nxt = sphda_pkg::ST_DONE;
          end
        end
      end
      sphda_pkg::ST_DIFF: begin
        // A span of 2^31 or more is halved together with h to keep squares in 64 bits.
        ax_nxt    = big_d ? dxa[32:1] : dxa[31:0];
        ay_nxt    = big_d ? dya[32:1] : dya[31:0];
        az_nxt    = big_d ? dza[32:1] : dza[31:0];
        hh_nxt    = big_d ? {1'b0, own_h_r[31:1]} : own_h_r;
        state_nxt = sphda_pkg::ST_SQX;
      end
      sphda_pkg::ST_SQX: begin
        mul_go = !run_r;  mul_ina = {32'b0, ax_r};  mul_inb = {1'b0, ax_r};
        if (fin) begin
          d2_nxt    = acc_r[63:0];
          state_nxt = sphda_pkg::ST_SQY;
        end
      end
      sphda_pkg::ST_SQY: begin
        mul_go = !run_r;  mul_ina = {32'b0, ay_r};  mul_inb = {1'b0, ay_r};
        if (fin) begin
          d2_nxt    = d2_r + acc_r[63:0];
          state_nxt = sphda_pkg::ST_SQZ;
        end
      end
      sphda_pkg::ST_SQZ: begin
        mul_go = !run_r;  mul_ina = {32'b0, az_r};  mul_inb = {1'b0, az_r};
        if (fin) begin
          d2_nxt    = d2_r + acc_r[63:0];
          state_nxt = sphda_pkg::ST_HSQ;
        end
      end
      sphda_pkg::ST_HSQ: begin
        mul_go = !run_r;  mul_ina = {32'b0, hh_r};  mul_inb = {1'b0, hh_r};
        if (fin) begin
          if (({4'b0, d2_r[63:4]} >= acc_r[63:0]) || (hh_r == 32'd0)) begin
            u_nxt     = sphda_pkg::U_SAT;
            state_nxt = sphda_pkg::ST_T;
          end else begin
            state_nxt = sphda_pkg::ST_SQRT;
          end
        end
      end
      sphda_pkg::ST_SQRT: begin
        sqrt_go = !run_r;
        if (fin) begin
          state_nxt = sphda_pkg::ST_UDIV;
        end
      end
      sphda_pkg::ST_UDIV: begin
        div_go  = !run_r;
        div_num = {root_r, 16'b0, 80'b0};
        div_den = {64'b0, hh_r};
        div_w   = sphda_pkg::DIV_W_U;
        if (fin) begin
          u_nxt     = (q_r > 64'(sphda_pkg::U_SAT)) ? sphda_pkg::U_SAT : q_r[18:0];
          state_nxt = sphda_pkg::ST_T;
        end
      end
      sphda_pkg::ST_T: begin
        if (u_r == 19'd0) begin
          c6_nxt    = sphda_pkg::ONE_Q30;
          state_nxt = sphda_pkg::ST_MK;
        end else begin
          mul_go  = !run_r;
          mul_ina = {33'b0, sphda_pkg::PIH_Q30};
          mul_inb = {16'b0, g_val};
          if (fin) begin
            t_nxt     = acc_r[47:16];
            state_nxt = sphda_pkg::ST_T2;
          end
        end
      end
      sphda_pkg::ST_T2: begin
        mul_go = !run_r;  mul_ina = {32'b0, t_r};  mul_inb = {1'b0, t_r};
        if (fin) begin
          t2_nxt    = acc_r[61:30];
          p_nxt     = sphda_pkg::ONE_Q30;
          tk_nxt    = 3'd0;
          state_nxt = sphda_pkg::ST_TMUL;
        end
      end
      sphda_pkg::ST_TMUL: begin
        mul_go = !run_r;  mul_ina = {32'b0, t2_r};  mul_inb = {2'b0, p_r};
        if (fin) begin
          y_nxt     = acc_r[61:30];
          state_nxt = sphda_pkg::ST_TDIV;
        end
      end
      sphda_pkg::ST_TDIV: begin
        div_go  = !run_r;
        div_num = {y_r, 96'b0};
        div_den = {89'b0, sphda_pkg::taylor_div(tk_r)};
        div_w   = sphda_pkg::DIV_W_TAY;
        if (fin) begin
          p_nxt = sphda_pkg::ONE_Q30 - q_r[30:0];
          if (tk_r == sphda_pkg::TAYLOR_LAST) begin
            state_nxt = sphda_pkg::ST_S;
          end else begin
            tk_nxt    = tk_r + 3'd1;
            state_nxt = sphda_pkg::ST_TMUL;
          end
        end
      end
      sphda_pkg::ST_S: begin
        mul_go = !run_r;  mul_ina = {32'b0, t_r};  mul_inb = {2'b0, p_r};
        if (fin) begin
          s_nxt     = acc_r[61:30];
          state_nxt = sphda_pkg::ST_TH;
        end
      end
      sphda_pkg::ST_TH: begin
        mul_go  = !run_r;
        mul_ina = {33'b0, sphda_pkg::PIH_Q30};
        mul_inb = {14'b0, u_r};
        if (fin) begin
          theta_nxt = acc_r[48:16];
          state_nxt = sphda_pkg::ST_C;
        end
      end
      sphda_pkg::ST_C: begin
        div_go  = !run_r;
        div_num = {2'b0, s_r, 30'b0, 64'b0};
        div_den = {63'b0, theta_r};
        div_w   = sphda_pkg::DIV_W_SINC;
        if (fin) begin
          c_nxt     = (q_r > 64'(sphda_pkg::ONE_Q30)) ? sphda_pkg::ONE_Q30 : q_r[30:0];
          state_nxt = sphda_pkg::ST_C2;
        end
      end
      sphda_pkg::ST_C2: begin
        mul_go = !run_r;  mul_ina = {33'b0, c_r};  mul_inb = {2'b0, c_r};
        if (fin) begin
          c2_nxt    = acc_r[60:30];
          state_nxt = sphda_pkg::ST_C4;
        end
      end
      sphda_pkg::ST_C4: begin
        mul_go = !run_r;  mul_ina = {33'b0, c2_r};  mul_inb = {2'b0, c2_r};
        if (fin) begin
          c4_nxt    = acc_r[60:30];
          state_nxt = sphda_pkg::ST_C6;
        end
      end
      sphda_pkg::ST_C6: begin
        mul_go = !run_r;  mul_ina = {33'b0, c4_r};  mul_inb = {2'b0, c2_r};
        if (fin) begin
          c6_nxt    = acc_r[60:30];
          state_nxt = sphda_pkg::ST_MK;
        end
      end
      sphda_pkg::ST_MK: begin
        if (own_h_r == 32'd0) begin
          // Zero smoothing length saturates the term whatever the mass.
          do_acc    = 1'b1;
          acc_t     = sphda_pkg::DENS_MAX;
          acc_sat   = 1'b1;
          state_nxt = sphda_pkg::ST_DONE;
        end else begin
          mul_go = !run_r;  mul_ina = {32'b0, mass_r};  mul_inb = {1'b0, kreg_r};
          if (fin) begin
            mk_nxt    = acc_r[63:0];
            state_nxt = sphda_pkg::ST_N;
          end
        end
      end
      sphda_pkg::ST_N: begin
        mul_go = !run_r;  mul_ina = mk_r;  mul_inb = {c6_r, 2'b00};
        if (fin) begin
          n_nxt     = acc_r;
          state_nxt = sphda_pkg::ST_H2;
        end
      end
      sphda_pkg::ST_H2: begin
        mul_go = !run_r;  mul_ina = {32'b0, own_h_r};  mul_inb = {1'b0, own_h_r};
        if (fin) begin
          hsq_nxt   = acc_r[63:0];
          state_nxt = sphda_pkg::ST_H3;
        end
      end
      sphda_pkg::ST_H3: begin
        mul_go = !run_r;  mul_ina = hsq_r;  mul_inb = {1'b0, own_h_r};
        if (fin) begin
          hc_nxt    = acc_r[95:0];
          state_nxt = sphda_pkg::ST_TDV;
        end
      end
      sphda_pkg::ST_TDV: begin
        div_go  = !run_r;
        div_num = {n_r, 31'b0};
        div_den = hc_r;
        div_w   = sphda_pkg::DIV_W_TERM;
        if (fin) begin
          do_acc    = 1'b1;
          acc_t     = big_r ? sphda_pkg::DENS_MAX : q_r[47:0];
          acc_sat   = big_r;
          state_nxt = sphda_pkg::ST_DONE;
        end
      end
      sphda_pkg::ST_DONE: begin
        if (!last_r) begin
          state_nxt = sphda_pkg::ST_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_den_nxt   = dsum_r;
          out_ovf_nxt   = err_r;
          dsum_nxt      = '0;
          err_nxt       = 1'b0;
          nb_nxt        = '0;
          state_nxt     = sphda_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sphda_pkg::ST_IDLE;
      end
    endcase

    if (do_acc) begin
      if (sum49[48]) begin
        dsum_nxt = sphda_pkg::DENS_MAX;
        err_nxt  = 1'b1;
      end else begin
        dsum_nxt = sum49[47:0];
      end
      if (acc_sat) begin
        err_nxt = 1'b1;
      end
    end

    if (mul_go) begin
      mul_a_nxt = mul_ina;
      mul_b_nxt = mul_inb;
      acc_nxt   = '0;
      cnt_nxt   = sphda_pkg::MUL_STEPS;
      run_nxt   = 1'b1;
    end
    if (div_go) begin
      num_nxt = div_num;
      den_nxt = div_den;
      rem_nxt = '0;
      q_nxt   = '0;
      big_nxt = 1'b0;
      cnt_nxt = div_w;
      run_nxt = 1'b1;
    end
    if (sqrt_go) begin
      sv_nxt   = d2_r;
      srem_nxt = '0;
      root_nxt = '0;
      cnt_nxt  = sphda_pkg::SQRT_STEPS;
      run_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sphda_pkg::ST_IDLE;
      run_r       <= 1'b0;
      cnt_r       <= 7'd0;
      kreg_r      <= sphda_pkg::KNORM_RST;
      own_x_r     <= '0;
      own_y_r     <= '0;
      own_z_r     <= '0;
      own_h_r     <= '0;
      dsum_r      <= '0;
      err_r       <= 1'b0;
      nb_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_r       <= run_nxt;
      cnt_r       <= cnt_nxt;
      kreg_r      <= kreg_nxt;
      own_x_r     <= own_x_nxt;
      own_y_r     <= own_y_nxt;
      own_z_r     <= own_z_nxt;
      own_h_r     <= own_h_nxt;
      dsum_r      <= dsum_nxt;
      err_r       <= err_nxt;
      nb_r        <= nb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    pz_r      <= pz_nxt;
    mass_r    <= mass_nxt;
    last_r    <= last_nxt;
    out_den_r <= out_den_nxt;
    out_ovf_r <= out_ovf_nxt;
    mul_a_r   <= mul_a_nxt;
    mul_b_r   <= mul_b_nxt;
    acc_r     <= acc_nxt;
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    rem_r     <= rem_nxt;
    q_r       <= q_nxt;
    big_r     <= big_nxt;
    sv_r      <= sv_nxt;
    srem_r    <= srem_nxt;
    root_r    <= root_nxt;
    ax_r      <= ax_nxt;
    ay_r      <= ay_nxt;
    az_r      <= az_nxt;
    hh_r      <= hh_nxt;
    d2_r      <= d2_nxt;
    u_r       <= u_nxt;
    t_r       <= t_nxt;
    t2_r      <= t2_nxt;
    y_r       <= y_nxt;
    s_r       <= s_nxt;
    p_r       <= p_nxt;
    tk_r      <= tk_nxt;
    theta_r   <= theta_nxt;
    c_r       <= c_nxt;
    c2_r      <= c2_nxt;
    c4_r      <= c4_nxt;
    c6_r      <= c6_nxt;
    mk_r      <= mk_nxt;
    hsq_r     <= hsq_nxt;
    n_r       <= n_nxt;
    hc_r      <= hc_nxt;
  end

endmodule

// ===== sv/sphda_checker.sv =====
module sphda_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [47:0] out_density,
  input logic        out_overflow
);

  // A result held under stall keeps its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_density) && $stable(out_overflow))
    else $error("stalled result changed");

  // An accepted item always takes the block out of idle, so no second item is taken straight after it.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on two consecutive cycles");

  // Once saturated the sum stays at its ceiling until it is reported.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_density == 48'hFFFF_FFFF_FFFF)
    else $error("overflow reported below full scale");

  // Reset withdraws any pending result.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sph_density_accumulator sphda_checker u_sphda_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_density  (out_density),
  .out_overflow (out_overflow)
);
